>>> rtl/core/sist_pkg.sv
// Shared types, codes and constants for the sorted id set toggle block.
package sist_pkg;

	localparam int KEY_W      = 32;
	localparam int HALF_W     = 16;
	localparam int FUNC_W     = 2;
	localparam int IDX_W      = 8;
	localparam int STATUS_W   = 3;
	localparam int OUT_CNT_W  = 9;
	localparam int CAPACITY_DEF = 256;

	// Request functions.
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_TOGGLE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_READ   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_LOADED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd6;

	// Operations broadcast to every cell of the chain.
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_LOAD = 2'd1;
	localparam cell_op_t CELL_INS  = 2'd2;
	localparam cell_op_t CELL_DEL  = 2'd3;

	typedef struct packed {
		cell_op_t           op;
		logic               start;
		logic [KEY_W-1:0]   key;
	} cell_ctrl_t;

	typedef struct packed {
		logic stop;
		logic found;
	} cell_flag_t;

endpackage

>>> rtl/core/sist_if.sv
// Request and result channel interfaces of the sorted id set toggle block.
interface sist_req_if import sist_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic                chunk_start;
	logic [HALF_W-1:0]   obj_id;
	logic [HALF_W-1:0]   poly_id;
	logic [IDX_W-1:0]    read_index;

	modport source (output valid, func, chunk_start, obj_id, poly_id, read_index,
		input ready);
	modport sink (input valid, func, chunk_start, obj_id, poly_id, read_index,
		output ready);
endinterface

interface sist_rsp_if import sist_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [OUT_CNT_W-1:0] position;
	logic [OUT_CNT_W-1:0] entry_total;
	logic [HALF_W-1:0]    out_obj_id;
	logic [HALF_W-1:0]    out_poly_id;

	modport source (output valid, status, position, entry_total, out_obj_id,
		out_poly_id, input ready);
	modport sink (input valid, status, position, entry_total, out_obj_id,
		out_poly_id, output ready);
endinterface

>>> rtl/core/sorted_id_set_toggle.sv
// Top level of the sorted id set toggle block: request control, counters and result register.
//
//  channel | direction | handshake     | payload
//  req     | in        | valid / ready | func, chunk_start, obj_id, poly_id, read_index
//  rsp     | out       | valid / ready | status, position, entry_total, out_obj_id, out_poly_id
//
// Clear, load and read go from acceptance straight to the done state. A toggle first scans
// from the search start to the position found: the search token steps one cell per cycle
// along the key chain. The shift is made in the done state, once the output register is free.
// Reset empties the list and the search hint; key cells are not cleared.
// A request is taken while the previous result still waits in the output register;
// a finished request then waits until that register is free.
module sorted_id_set_toggle import sist_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sist_req_if.sink   req,
	sist_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > IDX_W) ? CW : IDX_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [FUNC_W-1:0]  func_q;
	logic [KEY_W-1:0]   key_q;
	logic [PW-1:0]      pos_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      hint_q;
	logic               found_q;

	logic [STATUS_W-1:0]  status_q;
	logic [OUT_CNT_W-1:0] position_q;
	logic [OUT_CNT_W-1:0] total_q;
	logic [KEY_W-1:0]     out_key_q;
	logic                 out_valid_q;

	logic               accept;
	logic               out_free;
	logic               full;
	logic               in_list;
	logic               stop;
	logic [CW-1:0]      start_cnt;
	logic [PW-1:0]      start_pos;
	logic [PW-1:0]      count_pos;
	cell_ctrl_t         ctrl;
	logic [PW-1:0]      bus_pos;
	cell_flag_t         flag;
	logic [KEY_W-1:0]   rd_key;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign full      = (count_q >= CW'(CAPACITY));
	assign count_pos = PW'(count_q);
	assign in_list   = (pos_q < count_pos);
	assign stop      = !in_list || flag.stop;

	assign start_cnt = req.chunk_start ? '0 : ((hint_q > count_q) ? count_q : hint_q);
	assign start_pos = PW'(start_cnt);
	assign bus_pos   = (state_q == S_IDLE) ? start_pos : pos_q;

	always_comb begin
		ctrl.op    = CELL_HOLD;
		ctrl.start = (state_q == S_IDLE);
		ctrl.key   = key_q;
		if (state_q == S_DONE && out_free) begin
			case (func_q)
				FN_LOAD: begin
					if (!full) ctrl.op = CELL_LOAD;
				end
				FN_TOGGLE: begin
					if (found_q) ctrl.op = CELL_DEL;
					else if (!full) ctrl.op = CELL_INS;
				end
				default: begin
					ctrl.op = CELL_HOLD;
				end
			endcase
		end
	end

	sist_chain #(
		.CAPACITY (CAPACITY),
		.PW       (PW)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.pos    (bus_pos),
		.flag   (flag),
		.rd_key (rd_key)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			key_q  <= {req.obj_id, req.poly_id};
		end
		if (state_q == S_SCAN && stop) begin
			found_q <= in_list && flag.found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pos_q   <= '0;
			count_q <= '0;
			hint_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (req.func)
							FN_CLEAR: begin
								pos_q   <= '0;
								state_q <= S_DONE;
							end
							FN_LOAD: begin
								pos_q   <= count_pos;
								state_q <= S_DONE;
							end
							FN_TOGGLE: begin
								// The start becomes the hint, so a chunk start holds even on overflow.
								pos_q   <= start_pos;
								hint_q  <= start_cnt;
								state_q <= S_SCAN;
							end
							default: begin
								pos_q   <= PW'(req.read_index);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (stop) state_q <= S_DONE;
					else pos_q <= pos_q + 1'b1;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						case (func_q)
							FN_CLEAR: begin
								count_q <= '0;
								hint_q  <= '0;
							end
							FN_LOAD: begin
								if (!full) count_q <= count_q + 1'b1;
							end
							FN_TOGGLE: begin
								if (found_q) begin
									count_q <= count_q - 1'b1;
									hint_q  <= CW'(pos_q);
								end else if (!full) begin
									count_q <= count_q + 1'b1;
									hint_q  <= CW'(pos_q) + 1'b1;
								end
							end
							default: begin
								count_q <= count_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register; the count written here is the value after the operation.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			position_q <= OUT_CNT_W'(pos_q);
			out_key_q  <= '0;
			total_q    <= OUT_CNT_W'(count_q);
			case (func_q)
				FN_CLEAR: begin
					status_q <= ST_CLEARED;
					total_q  <= '0;
				end
				FN_LOAD: begin
					if (full) begin
						status_q <= ST_OVERFLOW;
					end else begin
						status_q <= ST_LOADED;
						total_q  <= OUT_CNT_W'(count_q + 1'b1);
					end
				end
				FN_TOGGLE: begin
					if (found_q) begin
						status_q <= ST_REMOVED;
						total_q  <= OUT_CNT_W'(count_q - 1'b1);
					end else if (full) begin
						status_q <= ST_OVERFLOW;
					end else begin
						status_q <= ST_INSERTED;
						total_q  <= OUT_CNT_W'(count_q + 1'b1);
					end
				end
				default: begin
					if (in_list) begin
						status_q  <= ST_READ;
						out_key_q <= rd_key;
					end else begin
						status_q <= ST_RANGE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.position    = position_q;
	assign rsp.entry_total = total_q;
	assign rsp.out_obj_id  = out_key_q[KEY_W-1:HALF_W];
	assign rsp.out_poly_id = out_key_q[HALF_W-1:0];

endmodule

>>> rtl/core/sist_cell.sv
// One cell of the key chain: holds one key and one bit of the search token.
module sist_cell import sist_pkg::*; #(
	parameter int PW  = 9,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [PW-1:0]    pos,
	input  logic [KEY_W-1:0] prev_key,
	input  logic [KEY_W-1:0] next_key,
	input  logic             carry_in,
	output logic [KEY_W-1:0] key,
	output logic             carry_out,
	output cell_flag_t       flag,
	output logic [KEY_W-1:0] rd_key
);

	logic [KEY_W-1:0] key_q;
	logic             tok_q;
	logic             at_pos;
	logic             above;
	logic             lt;

	assign at_pos = (pos == PW'(IDX));
	assign above  = (pos < PW'(IDX));
	assign lt     = (key_q < ctrl.key);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_LOAD: begin
				if (at_pos) key_q <= ctrl.key;
			end
			CELL_INS: begin
				if (at_pos) key_q <= ctrl.key;
				else if (above) key_q <= prev_key;
			end
			CELL_DEL: begin
				if (at_pos || above) key_q <= next_key;
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	// The token enters at the start cell and moves up while the keys stay below the request key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctrl.start) begin
			tok_q <= at_pos;
		end else begin
			tok_q <= carry_in;
		end
	end

	assign key        = key_q;
	assign carry_out  = tok_q & lt;
	assign flag.stop  = tok_q & ~lt;
	assign flag.found = tok_q & (key_q == ctrl.key);
	assign rd_key     = at_pos ? key_q : '0;

endmodule

>>> rtl/core/sist_chain.sv
// Row of key cells with neighbor links and the flag and read-data reduction.
module sist_chain import sist_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int PW       = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [PW-1:0]    pos,
	output cell_flag_t       flag,
	output logic [KEY_W-1:0] rd_key
);

	logic [KEY_W-1:0] keys [CAPACITY];
	logic [KEY_W-1:0] rd   [CAPACITY];
	logic             carry [CAPACITY];
	cell_flag_t       flags [CAPACITY];

	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic [KEY_W-1:0] prev_key;
		logic [KEY_W-1:0] next_key;
		logic             carry_in;

		if (j == 0) begin : g_first
			assign prev_key = keys[j];
			assign carry_in = 1'b0;
		end else begin : g_mid
			assign prev_key = keys[j-1];
			assign carry_in = carry[j-1];
		end
		if (j == CAPACITY - 1) begin : g_last
			assign next_key = keys[j];
		end else begin : g_body
			assign next_key = keys[j+1];
		end

		sist_cell #(
			.PW  (PW),
			.IDX (j)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.pos       (pos),
			.prev_key  (prev_key),
			.next_key  (next_key),
			.carry_in  (carry_in),
			.key       (keys[j]),
			.carry_out (carry[j]),
			.flag      (flags[j]),
			.rd_key    (rd[j])
		);
	end

	// At most one cell holds the token, and at most one matches the position.
	always_comb begin
		flag   = '0;
		rd_key = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			flag.stop  = flag.stop | flags[j].stop;
			flag.found = flag.found | flags[j].found;
			rd_key     = rd_key | rd[j];
		end
	end

endmodule
